FILE: rtl/core/esc_pkg.sv
// Shared types, constants and elaboration-time table builders for the
// escape-time smooth colorizer. No dependencies.
package esc_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int PIPE_DEPTH = 8;

	// 128 in units of 2^-48.
	localparam logic [63:0] BAILOUT_Q48 = 64'd128 << 48;
	// 2^22 plus round(log2(14)*2^16) minus round(1.28*2^16).
	localparam logic signed [34:0] X_OFFSET = 35'sd4359937;
	localparam logic [32:0] X_MIN_Q22 = 33'd256;
	localparam logic [15:0] PHASE_Q16 = 16'd29491;

	localparam int STOP_POS [6] = '{0, 10486, 27525, 42107, 56197, 65536};
	localparam int STOP_R [6] = '{0, 32, 237, 255, 0, 0};
	localparam int STOP_G [6] = '{7, 107, 255, 170, 2, 7};
	localparam int STOP_B [6] = '{100, 203, 255, 0, 0, 100};

	typedef struct packed {
		logic signed [31:0] z_real;
		logic signed [31:0] z_imag;
		logic [15:0] iter_count;
		logic frame_end;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic inside_set;
		logic frame_end_out;
	} pix_out_t;

	typedef logic [15:0] log2_lut_t [256];

	// Entry k is the fraction of log2(1 + k/256), found one bit per squaring.
	function automatic log2_lut_t build_log2_lut();
		log2_lut_t lut;
		logic [63:0] x;
		logic [15:0] r;
		for (int k = 0; k < 256; k++) begin
			x = 64'(256 + k) << 22;
			r = '0;
			for (int b = 0; b < 16; b++) begin
				x = (x * x) >> 30;
				r = {r[14:0], 1'b0};
				if (x >= (64'd1 << 31)) begin
					r[0] = 1'b1;
					x = x >> 1;
				end
			end
			lut[k] = r;
		end
		return lut;
	endfunction

	localparam log2_lut_t LOG2_LUT = build_log2_lut();

	// Position of the highest set bit; zero for a zero word.
	function automatic logic [5:0] msb64(logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

endpackage

FILE: rtl/core/escape_time_smooth_colorizer.sv
// Top level of the escape-time smooth colorizer: an eight-stage pipeline from
// escaped z and iteration count to a palette color. Depends on esc_pkg.

// The block takes one pixel in every clock cycle and never raises busy; each
// pixel's color appears on result, with done high for one cycle, in input
// order, after passing the pipeline stages: magnitude, square, sum, three
// logarithm stages, the palette index multiply and the palette ROM read. The
// receiver cannot stall the block, so it must take every result in the cycle
// it is shown.
module escape_time_smooth_colorizer #(
	parameter int PALETTE_ENTRIES = esc_pkg::PALETTE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input esc_pkg::pix_in_t pixel,
	output logic done,
	output esc_pkg::pix_out_t result
);
	import esc_pkg::*;

	localparam int IW = $clog2(PALETTE_ENTRIES);
	localparam int PW = 17 + $clog2(PALETTE_ENTRIES + 1);

	// Palette ROM, built at elaboration from the gradient stops.
	logic [23:0] pal [PALETTE_ENTRIES];

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_pal
		localparam int T = (i * 65536) / PALETTE_ENTRIES;
		localparam int S = (T >= STOP_POS[4]) ? 4 : (T >= STOP_POS[3]) ? 3 :
			(T >= STOP_POS[2]) ? 2 : (T >= STOP_POS[1]) ? 1 : 0;
		localparam int SPAN = STOP_POS[S + 1] - STOP_POS[S];
		localparam int DT = T - STOP_POS[S];
		localparam int RV = STOP_R[S] + ((STOP_R[S + 1] - STOP_R[S]) * DT) / SPAN;
		localparam int GV = STOP_G[S] + ((STOP_G[S + 1] - STOP_G[S]) * DT) / SPAN;
		localparam int BV = STOP_B[S] + ((STOP_B[S + 1] - STOP_B[S]) * DT) / SPAN;
		assign pal[i] = {8'(RV), 8'(GV), 8'(BV)};
	end

	logic [PIPE_DEPTH-1:0] vld_q;

	logic [31:0] ar_s1, ai_s1;
	logic [63:0] sr_s2, si_s2, mag_s3;
	logic [19:0] l_s4;
	logic [32:0] x_s5;
	logic [15:0] f_s6;
	logic [IW-1:0] idx_s7;
	logic [15:0] n_s1, n_s2, n_s3, n_s4;
	logic [6:0] fe_q;
	logic [4:0] ins_q;

	logic [5:0] p4, p5, p6;
	logic [7:0] k4, k5, k6;
	logic [17:0] logl5;
	logic signed [34:0] xs5;
	logic [PW-1:0] prod7;
	logic [PW-17:0] idx7;

	assign busy = 1'b0;

	always_comb begin
		p4 = msb64(mag_s3);
		k4 = 8'(mag_s3 >> (p4 - 6'd8));
		p5 = msb64({44'd0, l_s4});
		k5 = 8'(l_s4 >> (p5 - 6'd8));
		logl5 = {2'(p5 - 6'd16), LOG2_LUT[k5]};
		xs5 = $signed({3'b000, n_s4, 16'h0000}) + X_OFFSET - $signed({17'd0, logl5});
		p6 = msb64({31'd0, x_s5});
		k6 = 8'(x_s5 >> (p6 - 6'd8));
		prod7 = PW'(f_s6) * PW'(PALETTE_ENTRIES) + PW'(32768);
		idx7 = prod7[PW-1:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		ar_s1 <= pixel.z_real[31] ? 32'(-pixel.z_real) : pixel.z_real;
		ai_s1 <= pixel.z_imag[31] ? 32'(-pixel.z_imag) : pixel.z_imag;
		n_s1 <= pixel.iter_count;
		sr_s2 <= ar_s1 * ar_s1;
		si_s2 <= ai_s1 * ai_s1;
		n_s2 <= n_s1;
		mag_s3 <= sr_s2 + si_s2;
		n_s3 <= n_s2;
		ins_q[0] <= (sr_s2 + si_s2) < BAILOUT_Q48;
		l_s4 <= {4'(p4 - 6'd48), LOG2_LUT[k4]};
		n_s4 <= n_s3;
		x_s5 <= (xs5 < $signed({2'b00, X_MIN_Q22})) ? X_MIN_Q22 : 33'(xs5);
		f_s6 <= LOG2_LUT[k6] + PHASE_Q16;
		idx_s7 <= (idx7 >= (PW-16)'(PALETTE_ENTRIES)) ? '0 : IW'(idx7);
		ins_q[4:1] <= ins_q[3:0];
		fe_q <= {fe_q[5:0], pixel.frame_end};
		// Inside pixels are black whatever index their garbage math produced.
		if (ins_q[4]) begin
			{result.red, result.green, result.blue} <= '0;
		end else begin
			{result.red, result.green, result.blue} <= pal[idx_s7];
		end
		result.inside_set <= ins_q[4];
		result.frame_end_out <= fe_q[6];
	end

	assign done = vld_q[PIPE_DEPTH-1];

endmodule

FILE: rtl/core/esc_checker.sv
// Port-level checker for the escape-time smooth colorizer, bound to the top.
// Depends on esc_pkg for the pipeline depth and payload types.
module esc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input esc_pkg::pix_in_t pixel,
	input logic done,
	input esc_pkg::pix_out_t result
);
	import esc_pkg::*;

	// A result is only shown for a matching earlier input transfer.
	a_done_has_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("result without matching input transfer");

	a_inside_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.inside_set) |->
		(result.red == 8'd0 && result.green == 8'd0 && result.blue == 8'd0))
		else $error("inside pixel is not black");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.frame_end_out == $past(pixel.frame_end, PIPE_DEPTH)))
		else $error("frame end flag out of step");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind escape_time_smooth_colorizer esc_checker u_esc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.pixel(pixel),
	.done(done),
	.result(result)
);
